@@ rtl/pip_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants of the point-in-polygon test
// Request codes, store sizing, result kinds and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 16;
  localparam int TOTAL_W      = 7;
  localparam int MIN_VERTICES = 3;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_FEW  = 2'd1;
  localparam logic [1:0] STS_DROP = 2'd2;

  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_FEW,
    RES_DROP,
    RES_QUERY
  } pip_res_kind_t;

  typedef struct packed {
    logic             wr_en;
    logic             wr_first;
    logic             query_start;
    logic             rd_en;
    logic             edge_en;
    logic [IDX_W-1:0] rd_addr;
    logic             result_en;
    pip_res_kind_t    res_kind;
  } pip_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
  } pip_sts_t;

endpackage

@@ rtl/pip_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ctrl: request sequencer
// Decodes requests, walks the vertex store for queries and raises the
// result strobe.
// ----------------------------------------------------------------------------
module pip_ctrl import pip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_req_type,
  input  pip_sts_t   sts,
  output pip_cmd_t   cmd,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             drain_r, drain_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.res_kind  = RES_PLAIN;
    state_nxt     = state_r;
    k_nxt         = k_r;
    drain_nxt     = drain_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_req_type)
            REQ_START: begin
              cmd.wr_en     = 1'b1;
              cmd.wr_first  = 1'b1;
              cmd.result_en = 1'b1;
            end
            REQ_APPEND: begin
              cmd.result_en = 1'b1;
              if (sts.full) begin
                cmd.res_kind = RES_DROP;
              end else begin
                cmd.wr_en = 1'b1;
              end
            end
            REQ_QUERY: begin
              if (sts.count < CNT_W'(MIN_VERTICES)) begin
                cmd.result_en = 1'b1;
                cmd.res_kind  = RES_FEW;
              end else begin
                cmd.query_start = 1'b1;
                state_nxt       = S_WALK;
                k_nxt           = '0;
              end
            end
            default: begin
              cmd.result_en = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        // read vertices 0..n-1, then vertex 0 again to close the polygon
        cmd.rd_en   = 1'b1;
        cmd.edge_en = (k_r != '0);
        cmd.rd_addr = (k_r == sts.count) ? '0 : k_r[IDX_W-1:0];
        if (k_r == sts.count) begin
          state_nxt = S_DRAIN;
          drain_nxt = 1'b0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (drain_r) begin
          state_nxt = S_DONE;
        end else begin
          drain_nxt = 1'b1;
        end
      end
      S_DONE: begin
        cmd.result_en = 1'b1;
        cmd.res_kind  = RES_QUERY;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.result_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/pip_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_datapath: vertex store and edge evaluation pipeline
// Holds the polygon, evaluates one edge per cycle against the query point
// and registers the result beat.
// ----------------------------------------------------------------------------
module pip_datapath import pip_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pip_cmd_t                  cmd,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output pip_sts_t                  sts,
  output logic                      out_inside_res,
  output logic                      out_on_boundary,
  output logic [1:0]                out_status,
  output logic [TOTAL_W-1:0]        out_vertex_total
);

  logic [2*COORD_W-1:0] mem [MAX_VERTICES];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] wr_addr;

  // query point
  logic signed [COORD_W-1:0] px_r, py_r;

  // read stage
  logic signed [COORD_W-1:0] x2_r, y2_r, x1_r, y1_r;
  logic                      v1_r, e1_r;

  // product stage
  logic signed [PROD_W-1:0] p_r, q_r;
  logic                     straddle_r, dypos_r, bbox_r, e2_r;

  // accumulators
  logic bnd_r, par_r;

  // results
  logic               inside_r, boundary_r;
  logic [1:0]         status_r;
  logic [TOTAL_W-1:0] total_r;

  logic signed [DIFF_W-1:0] dpx, dpy, ddx, ddy;
  logic signed [PROD_W-1:0] p_nxt, q_nxt;
  logic                     on_seg, crosses;

  always_comb begin
    count_nxt = count_r;
    wr_addr   = count_r[IDX_W-1:0];
    if (cmd.wr_en) begin
      if (cmd.wr_first) begin
        count_nxt = CNT_W'(1);
        wr_addr   = '0;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  assign sts.count = count_r;
  assign sts.full  = (count_r == CNT_W'(MAX_VERTICES));

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {in_coord_x, in_coord_y};
    end
    if (cmd.rd_en) begin
      {x2_r, y2_r} <= mem[cmd.rd_addr];
    end
  end

  // edge runs from (x1,y1) to (x2,y2); both products share their factors
  // between the on-edge test and the ray test
  always_comb begin
    dpx   = DIFF_W'(px_r) - DIFF_W'(x1_r);
    dpy   = DIFF_W'(py_r) - DIFF_W'(y1_r);
    ddx   = DIFF_W'(x2_r) - DIFF_W'(x1_r);
    ddy   = DIFF_W'(y2_r) - DIFF_W'(y1_r);
    p_nxt = dpx * ddy;
    q_nxt = dpy * ddx;
  end

  assign on_seg  = (p_r == q_r) && bbox_r;
  assign crosses = straddle_r && (dypos_r ? (p_r < q_r) : (p_r > q_r));

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      px_r <= in_coord_x;
      py_r <= in_coord_y;
    end
    if (v1_r) begin
      x1_r <= x2_r;
      y1_r <= y2_r;
    end
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    straddle_r <= (y1_r > py_r) != (y2_r > py_r);
    dypos_r    <= (y2_r > y1_r);
    bbox_r     <= ((px_r >= x1_r) || (px_r >= x2_r)) && ((px_r <= x1_r) || (px_r <= x2_r))
               && ((py_r >= y1_r) || (py_r >= y2_r)) && ((py_r <= y1_r) || (py_r <= y2_r));
    if (cmd.result_en) begin
      total_r <= TOTAL_W'(count_nxt);
      case (cmd.res_kind)
        RES_FEW: begin
          inside_r   <= 1'b0;
          boundary_r <= 1'b0;
          status_r   <= STS_FEW;
        end
        RES_DROP: begin
          inside_r   <= 1'b0;
          boundary_r <= 1'b0;
          status_r   <= STS_DROP;
        end
        RES_QUERY: begin
          inside_r   <= bnd_r | par_r;
          boundary_r <= bnd_r;
          status_r   <= STS_OK;
        end
        default: begin
          inside_r   <= 1'b0;
          boundary_r <= 1'b0;
          status_r   <= STS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      v1_r    <= 1'b0;
      e1_r    <= 1'b0;
      e2_r    <= 1'b0;
      bnd_r   <= 1'b0;
      par_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      v1_r    <= cmd.rd_en;
      e1_r    <= cmd.rd_en & cmd.edge_en;
      e2_r    <= e1_r;
      if (cmd.query_start) begin
        bnd_r <= 1'b0;
        par_r <= 1'b0;
      end else if (e2_r) begin
        bnd_r <= bnd_r | on_seg;
        par_r <= par_r ^ crosses;
      end
    end
  end

  assign out_inside_res   = inside_r;
  assign out_on_boundary  = boundary_r;
  assign out_status       = status_r;
  assign out_vertex_total = total_r;

endmodule

@@ rtl/point_in_polygon_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test: even-odd point-in-polygon unit
// Stores one polygon of up to MAX_VERTICES vertices and answers point
// queries, reporting on-edge points as inside.
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low; its result beat
// appears on the out_ ports for exactly one cycle, flagged by out_valid, and
// must be taken then, as the block cannot be held off. Vertex loads, unused
// request codes and queries against fewer than three vertices give their
// result in the cycle after acceptance without raising busy, so such beats
// may follow one another every cycle. A query over n stored vertices walks
// the vertex memory through its single read port, one vertex per cycle, n+1
// reads in all (the first vertex is read again to close the polygon), then
// waits out a two-stage edge pipeline; busy stays high throughout, so no
// other beat is taken until the query's result has appeared. Points on an
// edge are found by an exact zero cross product within the edge's bounding
// box; all other points are decided by the parity of crossings of a ray
// towards +x, compared by cross multiplication, with no rounding anywhere.
// A start beat replaces the polygon with its single vertex; an append to a
// full store is dropped and flagged. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module point_in_polygon_test import pip_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_req_type,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output logic                      out_valid,
  output logic                      out_inside_res,
  output logic                      out_on_boundary,
  output logic [1:0]                out_status,
  output logic [TOTAL_W-1:0]        out_vertex_total
);

  // command and status bundles between sequencer and datapath
  pip_cmd_t cmd;
  pip_sts_t sts;

  // sequencer: decode the beat, drive the store walk, strobe the result
  pip_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  // datapath: vertex memory, edge tests and result registers
  pip_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .sts              (sts),
    .out_inside_res   (out_inside_res),
    .out_on_boundary  (out_on_boundary),
    .out_status       (out_status),
    .out_vertex_total (out_vertex_total)
  );

endmodule

@@ rtl/pip_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_checker: port-level checks of the point-in-polygon unit
// Watches the top level's ports and flags results that break its rules.
// ----------------------------------------------------------------------------
module pip_checker import pip_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                in_req_type,
  input logic                      out_valid,
  input logic                      out_inside_res,
  input logic                      out_on_boundary,
  input logic [1:0]                out_status,
  input logic [TOTAL_W-1:0]        out_vertex_total
);

  logic accept;
  assign accept = start && !busy;

  // a load or unused-code beat answers in the next cycle, never inside
  a_load_answers: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req_type != REQ_QUERY) |=> out_valid && !out_inside_res)
    else $error("load beat did not answer at once");

  // a start beat leaves exactly one vertex
  a_start_one: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req_type == REQ_START) |=> out_vertex_total == TOTAL_W'(1))
    else $error("start beat did not leave one vertex");

  // a boundary hit is inside and carries ok status
  a_bnd_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_on_boundary |-> out_inside_res && (out_status == STS_OK))
    else $error("boundary result not inside or not ok");

  // the vertex total never exceeds the store
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vertex_total <= TOTAL_W'(MAX_VERTICES))
    else $error("vertex total beyond capacity");

  // a result strobe lasts one cycle unless a fresh beat was taken
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !accept |=> !out_valid)
    else $error("result strobe held without a new beat");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);
